### rtl/bba_pkg.sv
// bba_pkg: shared types and codes for the block bitmap allocator
// used by the top level and its bound checker; no dependencies

package bba_pkg;

  localparam int REQ_W = 3;
  localparam int IDX_W = 12;
  localparam int CNT_W = 13;
  localparam int ST_W  = 2;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  localparam logic [REQ_W-1:0] REQ_FORMAT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FREE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MARK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;

  localparam logic CFG_NUM_BLOCKS = 1'b0;
  localparam logic CFG_RESERVED   = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FMT,
    S_SCAN,
    S_DIV,
    S_ADDR,
    S_RMW,
    S_DONE
  } state_t;

endpackage

### rtl/block_bitmap_allocator_top.sv
// block_bitmap_allocator_top: used/free bitmap in one word-wide ram plus free counter
// depends on bba_pkg
//
// usage: one request enters on the s_ channel (tuser = request type, tdata = block
// index) and exactly one result leaves on the m_ channel (tuser = status, tdata =
// block number, used bit and free count). num_blocks and reserved_blocks are set
// through the cfg write port while no request is in flight.
// one request at a time; s_tready is high only while the block waits for work.
// steps from accept to m_tvalid:
//   format: one bitmap word written per cycle, then the result
//   allocate: one word read and tested per cycle until a free bit or the end of the map
//   free, mark used, query: index split, ram read, write back, result
//   range error, unknown request, allocate with zero count: straight to the result
// the ram port (one word per cycle) sets the pace of the allocate and format passes
// reset: control state, count and configuration go to their reset values, then a
// clearing pass writes zero to all MAP_WORDS ram words with s_tready low; cfg
// writes are taken during the pass
// a result waits in the output register while m_tready is low; the next request
// can be accepted meanwhile but its result holds until the register frees

module block_bitmap_allocator_top
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // block_index[11:0], zero fill
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // block_number[11:0], bit_value[12], free_count[25:13]
  output logic [1:0]  m_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW    = $clog2(WORD_BITS);
  localparam int BW    = $clog2(MAP_WORDS * WORD_BITS + WORD_BITS + 1);
  localparam int CW    = ((BW > CNT_W) ? BW : CNT_W) + 1;
  localparam int DIV_K = IDX_W + 1;
  localparam int RECIP = (1 << DIV_K) / WORD_BITS;
  localparam int PRW   = IDX_W + DIV_K + 1;
  localparam int MW    = IDX_W + 8;
  localparam logic [AW-1:0]    LAST_W = AW'(MAP_WORDS - 1);
  localparam logic [CNT_W-1:0] MAX_N  = CNT_W'((MAX_BLOCKS > 8191) ? 8191 : MAX_BLOCKS);
  localparam logic [CW-1:0]    W_X    = CW'(WORD_BITS);

  state_t state, state_next;

  logic [CNT_W-1:0] num_blocks, reserved_blocks, free_blocks;
  logic [CNT_W-1:0] n_eff, r_eff;

  logic [REQ_W-1:0] req;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] q0;
  logic [AW-1:0]    word_q;
  logic [PW-1:0]    pos_q;
  logic [AW-1:0]    rd_w, chk_w;
  logic [CW-1:0]    base;
  logic             chk_valid;

  logic [ST_W-1:0]  res_status;
  logic [IDX_W-1:0] res_block;
  logic             res_bit;

  logic [ST_W-1:0]  m_status;
  logic [IDX_W-1:0] m_block;
  logic             m_bit;
  logic [CNT_W-1:0] m_count;

  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic             accept, out_free, in_range;
  logic [REQ_W-1:0] in_req;
  logic [IDX_W-1:0] in_idx;

  logic [WORD_BITS-1:0] fmt_word, iso, rmw_word;
  logic [CW-1:0]        r_x, n_x, r_rem;
  logic [PW-1:0]        zpos;
  logic                 full, scan_found, scan_fail, old_bit;
  logic [PRW-1:0]       prod;
  logic [MW-1:0]        rem;
  logic                 adj;
  logic [AW-1:0]        word_c;
  logic [PW-1:0]        pos_c;
  logic [CW-1:0]        found_b;

  assign in_req   = s_tuser;
  assign in_idx   = s_tdata[IDX_W-1:0];
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign n_eff    = (32'(num_blocks) > MAX_BLOCKS) ? MAX_N : num_blocks;
  assign r_eff    = (reserved_blocks > n_eff) ? n_eff : reserved_blocks;
  assign in_range = {1'b0, in_idx} < n_eff;
  assign n_x      = CW'(n_eff);
  assign r_x      = CW'(r_eff);
  assign r_rem    = r_x - base;

  // format word: bits below the reserved limit set
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      fmt_word[j] = (r_x > base) && (CW'(j) < r_rem);
    end
  end

  // lowest clear bit of the word under test
  assign iso  = ~rdata & (rdata + WORD_BITS'(1));
  assign full = &rdata;
  always_comb begin
    zpos = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (iso[j]) zpos = zpos | PW'(j);
    end
  end
  assign found_b    = base + CW'(zpos);
  assign scan_found = chk_valid && !full && (found_b < n_x);
  assign scan_fail  = chk_valid && ((!full && !(found_b < n_x)) || (full && (base + W_X >= n_x)));

  // word and bit split of the block index
  assign prod   = PRW'(idx) * PRW'(RECIP);
  assign rem    = MW'(idx) - MW'(q0) * MW'(WORD_BITS);
  assign adj    = rem >= MW'(WORD_BITS);
  assign word_c = AW'(q0 + IDX_W'(adj));
  assign pos_c  = adj ? PW'(rem - MW'(WORD_BITS)) : PW'(rem);

  assign old_bit = rdata[pos_q];
  always_comb begin
    rmw_word = rdata;
    case (req)
      REQ_FREE: rmw_word[pos_q] = 1'b0;
      REQ_MARK: rmw_word[pos_q] = 1'b1;
      default:  rmw_word[pos_q] = old_bit;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (rd_w == LAST_W) state_next = S_IDLE;
      S_IDLE: begin
        if (s_tvalid) begin
          case (in_req) inside
            REQ_FORMAT: state_next = S_FMT;
            REQ_ALLOC:  state_next = (free_blocks == '0) ? S_DONE : S_SCAN;
            REQ_FREE, REQ_MARK, REQ_QUERY: state_next = in_range ? S_DIV : S_DONE;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_FMT:  if (rd_w == LAST_W) state_next = S_DONE;
      S_SCAN: if (scan_found || scan_fail) state_next = S_DONE;
      S_DIV:  state_next = S_ADDR;
      S_ADDR: state_next = S_RMW;
      S_RMW:  state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = rd_w;
    mem_raddr = rd_w;
    mem_wdata = '0;
    unique case (state)
      S_CLEAR: mem_we = 1'b1;
      S_IDLE:  s_tready = 1'b1;
      S_FMT: begin
        mem_we    = 1'b1;
        mem_wdata = fmt_word;
      end
      S_SCAN: begin
        mem_re = 1'b1;
        if (scan_found) begin
          mem_we    = 1'b1;
          mem_waddr = chk_w;
          mem_wdata = rdata | iso;
        end
      end
      S_ADDR: begin
        mem_re    = 1'b1;
        mem_raddr = word_c;
      end
      S_RMW: begin
        mem_we    = 1'b1;
        mem_waddr = word_q;
        mem_wdata = rmw_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= map_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      m_tvalid        <= 1'b0;
      free_blocks     <= '0;
      num_blocks      <= CNT_W'(4096);
      reserved_blocks <= '0;
      rd_w            <= '0;
      chk_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_BLOCKS: num_blocks <= cfg_data;
          CFG_RESERVED:   reserved_blocks <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: rd_w <= rd_w + AW'(1);
        S_IDLE: begin
          if (accept) begin
            req        <= in_req;
            idx        <= in_idx;
            rd_w       <= '0;
            base       <= '0;
            chk_valid  <= 1'b0;
            res_status <= ST_OK;
            res_block  <= '0;
            res_bit    <= 1'b0;
            case (in_req) inside
              REQ_ALLOC: if (free_blocks == '0) res_status <= ST_NOFREE;
              REQ_FREE, REQ_MARK, REQ_QUERY: if (!in_range) res_status <= ST_RANGE;
              default: ;
            endcase
          end
        end
        S_FMT: begin
          rd_w <= rd_w + AW'(1);
          base <= base + W_X;
          if (rd_w == LAST_W) free_blocks <= n_eff - r_eff;
        end
        S_SCAN: begin
          rd_w      <= rd_w + AW'(1);
          chk_w     <= rd_w;
          chk_valid <= 1'b1;
          if (chk_valid) base <= base + W_X;
          if (scan_found) begin
            res_block <= IDX_W'(found_b);
            res_bit   <= 1'b1;
            if (free_blocks != '0) free_blocks <= free_blocks - CNT_W'(1);
          end else if (scan_fail) begin
            res_status <= ST_NOFREE;
          end
        end
        S_DIV: q0 <= IDX_W'(prod >> DIV_K);
        S_ADDR: begin
          word_q <= word_c;
          pos_q  <= pos_c;
        end
        S_RMW: begin
          res_block <= idx;
          case (req)
            REQ_FREE: begin
              res_bit <= 1'b0;
              if (old_bit && free_blocks != COUNT_MAX) free_blocks <= free_blocks + CNT_W'(1);
            end
            REQ_MARK: begin
              res_bit <= 1'b1;
              if (!old_bit && free_blocks != '0) free_blocks <= free_blocks - CNT_W'(1);
            end
            default: res_bit <= old_bit;
          endcase
        end
        S_DONE: begin
          if (out_free) begin
            m_status <= res_status;
            m_block  <= res_block;
            m_bit    <= res_bit;
            m_count  <= free_blocks;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = {6'b0, m_count, m_bit, m_block};
  assign m_tuser = m_status;

endmodule

### rtl/bba_checker.sv
// bba_checker: port-level assertions for block_bitmap_allocator_top
// depends on bba_pkg; bound to the top level at the end of this file

module bba_checker
  import bba_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [12:0] cfg_data
);

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_NOFREE || m_tuser == ST_RANGE) |-> m_tdata[12:0] == 13'd0)
    else $error("error result carries a block number or used bit");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_NOFREE || m_tuser == ST_RANGE))
    else $error("undefined status code");

  // clearing pass keeps the input closed right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("activity right after reset");

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (.*);

### test/tb_block_bitmap_allocator_top.sv
// testbench for block_bitmap_allocator_top: directed and random allocator requests,
// results checked against an in-bench bitmap and free count model
// depends on bba_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_block_bitmap_allocator_top;
  import bba_pkg::*;

  localparam int MAX_BLK     = 4096;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int HALF_ITEMS  = 64;
  localparam int HOLD_CYCLES = 500;
  localparam int SEGS        = 10;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
  } request_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] blk;
    logic             bitv;
    logic [CNT_W-1:0] cnt;
  } response_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [12:0] cfg_data = '0;

  // allocator model
  bit [MAX_BLK-1:0] used_bits = '0;
  logic [CNT_W-1:0] free_cnt = '0;
  int               cfg_num_blocks = 4096;
  int               cfg_reserved = 0;

  request_t  request_q[$];
  response_t expected_responses[$];
  request_t  next_req;
  response_t want;
  response_t got;

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  tx_idle_pct = 0;
  int  rx_stall_pct = 0;
  logic rx_hold = 1'b0;

  int tx_pct_tbl[4] = '{0, 52, 0, 32};
  int rx_pct_tbl[4] = '{0, 0, 52, 32};
  int seg_num[SEGS] = '{4096, 40, 1, 4096, 8191, 100, 0, 1000, 4096, 33};
  int seg_rsv[SEGS] = '{0, 5, 0, 4000, 100, 8191, 0, 37, 4096, 1};

  block_bitmap_allocator_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // block_index[11:0], zero fill
    .s_tuser  (s_tuser),   // req_type[2:0]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // block_number[11:0], bit_value[12], free_count[25:13]
    .m_tuser  (m_tuser),   // status[1:0]
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic response_t predict_response(input logic [REQ_W-1:0] req,
                                                 input logic [IDX_W-1:0] idx);
    response_t r;
    int n;
    int rsv;
    int b;
    bit found;
    r = '{status: ST_OK, blk: '0, bitv: 1'b0, cnt: '0};
    n = (cfg_num_blocks > MAX_BLK) ? MAX_BLK : cfg_num_blocks;
    found = 1'b0;
    case (req)
      REQ_FORMAT: begin
        rsv = (cfg_reserved > n) ? n : cfg_reserved;
        used_bits = '0;
        for (b = 0; b < rsv; b++) used_bits[b] = 1'b1;
        free_cnt = CNT_W'(n - rsv);
      end
      REQ_ALLOC: begin
        // zero count fails without looking at the map
        if (free_cnt != 0) begin
          for (b = 0; b < n && !found; b++) begin
            if (!used_bits[b]) begin
              found = 1'b1;
              used_bits[b] = 1'b1;
              free_cnt = free_cnt - 1'b1;
              r.blk = IDX_W'(b);
              r.bitv = 1'b1;
            end
          end
        end
        if (!found) r.status = ST_NOFREE;
      end
      REQ_FREE, REQ_MARK, REQ_QUERY: begin
        if (int'(idx) >= n) begin
          r.status = ST_RANGE;
        end else begin
          r.blk = idx;
          if (req == REQ_FREE) begin
            if (used_bits[idx]) begin
              used_bits[idx] = 1'b0;
              if (free_cnt != COUNT_MAX) free_cnt = free_cnt + 1'b1;
            end
          end else if (req == REQ_MARK) begin
            if (!used_bits[idx]) begin
              used_bits[idx] = 1'b1;
              if (free_cnt != 0) free_cnt = free_cnt - 1'b1;
            end
            r.bitv = 1'b1;
          end else begin
            r.bitv = used_bits[idx];
          end
        end
      end
      default: ;
    endcase
    r.cnt = free_cnt;
    return r;
  endfunction

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endfunction

  function automatic logic [IDX_W-1:0] random_index(input int n, input int lo);
    int hi;
    if ($urandom_range(9) == 0) return IDX_W'($urandom);
    if ($urandom_range(1) == 0) begin
      // window around the first free blocks after the reserved area
      lo = (lo > 8) ? lo - 8 : 0;
      hi = lo + 48;
    end else begin
      lo = 0;
      hi = n + 2;
    end
    if (hi > MAX_BLK - 1) hi = MAX_BLK - 1;
    if (lo > hi) lo = hi;
    return IDX_W'($urandom_range(hi, lo));
  endfunction

  function automatic request_t random_request(input int n, input int rsv);
    request_t it;
    int roll;
    roll = $urandom_range(99);
    it.idx = random_index(n, rsv);
    if (roll < 2)       it.req = REQ_FORMAT;
    else if (roll < 40) it.req = REQ_ALLOC;
    else if (roll < 60) it.req = REQ_FREE;
    else if (roll < 75) it.req = REQ_MARK;
    else if (roll < 96) it.req = REQ_QUERY;
    else                it.req = REQ_W'($urandom_range(7, 5));
    return it;
  endfunction

  task automatic push_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx);
    request_q.push_back('{req: req, idx: idx});
  endtask

  task automatic write_reg(input logic idx, input logic [12:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NUM_BLOCKS) cfg_num_blocks = val;
    else cfg_reserved = val;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (request_q.size() != 0 || s_tvalid || expected_responses.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_phase(input int p);
    tx_idle_pct = tx_pct_tbl[p % 4];
    rx_stall_pct = rx_pct_tbl[p % 4];
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        expected_responses.push_back(predict_response(s_tuser, s_tdata[IDX_W-1:0]));
      if (!s_tvalid || s_tready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_req = request_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= next_req.req;
          s_tdata <= {4'b0, next_req.idx};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{status: m_tuser, blk: m_tdata[11:0], bitv: m_tdata[12], cnt: m_tdata[25:13]};
        if (expected_responses.size() == 0) begin
          note_error($sformatf("unexpected transaction: st=%0d blk=%0d bit=%0d cnt=%0d",
                               got.status, got.blk, got.bitv, got.cnt));
        end else begin
          want = expected_responses.pop_front();
          if (got.status !== want.status || got.blk !== want.blk ||
              got.bitv !== want.bitv || got.cnt !== want.cnt)
            note_error($sformatf({"mismatch: exp st=%0d blk=%0d bit=%0d cnt=%0d",
                                  " got st=%0d blk=%0d bit=%0d cnt=%0d"},
                                 want.status, want.blk, want.bitv, want.cnt,
                                 got.status, got.blk, got.bitv, got.cnt));
        end
      end
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int eff;
    int rsv_eff;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // before the first format: count is zero
    @(negedge clk);
    set_phase(0);
    push_request(REQ_ALLOC, 12'd0);
    push_request(REQ_MARK, 12'd4095);
    push_request(REQ_QUERY, 12'd4095);
    push_request(REQ_FREE, 12'd4095);
    push_request(REQ_ALLOC, 12'd0);
    push_request(REQ_QUERY, 12'd0);
    push_request(3'd5, 12'hAAA);
    push_request(3'd6, 12'h555);
    push_request(3'd7, 12'hFFF);
    push_request(REQ_FORMAT, 12'hFFF);
    push_request(REQ_ALLOC, 12'hFFF);
    push_request(REQ_ALLOC, 12'd0);
    push_request(REQ_FREE, 12'd0);
    push_request(REQ_FREE, 12'd0);
    push_request(REQ_MARK, 12'd1);
    push_request(REQ_QUERY, 12'd2);
    push_request(REQ_MARK, 12'd0);
    wait_idle();

    // map nearly full, index range edges
    write_reg(CFG_NUM_BLOCKS, 13'd64);
    write_reg(CFG_RESERVED, 13'd63);
    @(negedge clk);
    push_request(REQ_FORMAT, 12'd0);
    push_request(REQ_ALLOC, 12'd0);
    push_request(REQ_ALLOC, 12'd0);
    push_request(REQ_FREE, 12'd4095);
    push_request(REQ_MARK, 12'd64);
    push_request(REQ_QUERY, 12'd63);
    push_request(REQ_FREE, 12'd63);
    push_request(REQ_QUERY, 12'd64);
    wait_idle();

    for (int s = 0; s < SEGS; s++) begin
      write_reg(CFG_NUM_BLOCKS, 13'(seg_num[s]));
      write_reg(CFG_RESERVED, 13'(seg_rsv[s]));
      eff = (seg_num[s] > MAX_BLK) ? MAX_BLK : seg_num[s];
      rsv_eff = (seg_rsv[s] > eff) ? eff : seg_rsv[s];
      for (int h = 0; h < 2; h++) begin
        @(negedge clk);
        set_phase(2 * s + h);
        if (s == 1 && h == 0) begin
          // long receiver stall while requests keep coming
          fork
            begin
              rx_hold <= 1'b1;
              repeat (HOLD_CYCLES) @(posedge clk);
              rx_hold <= 1'b0;
            end
          join_none
        end
        if (h == 0) push_request(REQ_FORMAT, IDX_W'($urandom));
        for (int k = 0; k < HALF_ITEMS; k++)
          request_q.push_back(random_request(eff, rsv_eff));
        wait_idle();
      end
    end

    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
